>>> rtl/core/polynomial_bisection_root_defines.svh
// ---------------------------------------------------------------------------
// Polynomial bisection root finder: assertion macros
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef POLYNOMIAL_BISECTION_ROOT_DEFINES_SVH
`define POLYNOMIAL_BISECTION_ROOT_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PBR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("polynomial_bisection_root: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define PBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("polynomial_bisection_root: next-cycle check failed");
`else
`define PBR_ASSERT_SAME(label, clk, rst, ante, cons)
`define PBR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/pbr_pkg.sv
// ---------------------------------------------------------------------------
// pbr_pkg
// Shared constants, codes, state types and interface structs of the
// polynomial bisection root finder.
// ---------------------------------------------------------------------------
package pbr_pkg;

   // Sizing of the polynomial and the number format.
   localparam int MAX_DEGREE = 7;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_DEPTH = MAX_DEGREE + 1;
   localparam int COEF_IDX_W = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

   // Fixed field widths.
   localparam int DEGREE_W   = 3;
   localparam int EPS_W      = 17;
   localparam int COEF_W     = 16;
   localparam int X_W        = 32;
   localparam int ACC_W      = 64;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int FULL_W     = 3 * MUL_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = EPS_W;

   // Reset values of the configuration registers.
   localparam logic [DEGREE_W-1:0] DEGREE_RESET = DEGREE_W'(0);
   localparam logic [EPS_W-1:0]    EPS_RESET    = EPS_W'(66);

   // Symmetric saturation limit of the accumulator.
   localparam logic [ACC_W-2:0] MAG_MAX = {(ACC_W-1){1'b1}};

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_FIND = 1'b1
   } pbr_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEGREE  = 1'b0,
      CSR_EPSILON = 1'b1
   } pbr_csr_type;

   typedef enum logic [0:0] {
      STATUS_FOUND   = 1'b0,
      STATUS_NO_ROOT = 1'b1
   } pbr_status_type;

   // Bisection sequencer.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL_LO,
      ST_EVAL_HI,
      ST_SPLIT,
      ST_EVAL_MID,
      ST_RESP
   } pbr_state_type;

   // Horner evaluator sequencer.
   typedef enum logic [2:0] {
      EV_IDLE,
      EV_ABS,
      EV_MUL_LO,
      EV_MUL_HI,
      EV_SCALE,
      EV_ADD,
      EV_DONE
   } pbr_ev_state_type;

   // Evaluation request and result between the sequencer and the evaluator.
   typedef struct packed {
      logic                  start;
      logic signed [X_W-1:0] x;
   } pbr_eval_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] value;
   } pbr_eval_rsp_type;

endpackage

>>> rtl/core/pbr_horner.sv
// ---------------------------------------------------------------------------
// pbr_horner
// Evaluates the polynomial at one point by Horner's rule in a saturating
// 64-bit accumulator, using one shared 32x32 multiplier over two passes.
// ---------------------------------------------------------------------------
module pbr_horner
   import pbr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic [DEGREE_W-1:0]          degree,
   input  pbr_eval_req_type             ev_req,
   output logic [COEF_IDX_W-1:0]        coef_idx,
   input  logic signed [COEF_W-1:0]     coef_val,
   output pbr_eval_rsp_type             ev_rsp
);

   pbr_ev_state_type        state_ff, state_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-2:0]        am_ff, am_in;
   logic [MUL_W-1:0]        xm_ff, xm_in;
   logic                    x_neg_ff, x_neg_in;
   logic                    neg_ff, neg_in;
   logic [PROD_W-1:0]       prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0]       prod_hi_ff, prod_hi_in;
   logic [ACC_W-2:0]        mag_ff, mag_in;
   logic [COEF_IDX_W-1:0]   idx_ff, idx_in;

   logic [COEF_IDX_W-1:0]   deg_eff;
   logic [MUL_W-1:0]        mul_a;
   logic [PROD_W-1:0]       mul_p;
   logic [FULL_W-1:0]       full;
   logic                    ovf;
   logic signed [ACC_W:0]   coef_wide;
   logic signed [ACC_W:0]   mag_wide;
   logic signed [ACC_W:0]   sum;
   logic signed [ACC_W:0]   sum_max;
   logic signed [ACC_W-1:0] coef_acc;

   // Degree beyond the store saturates to the top entry.
   assign deg_eff = (int'(degree) > MAX_DEGREE) ? COEF_IDX_W'(MAX_DEGREE)
                                                : COEF_IDX_W'(degree);

   // The leading coefficient is read at start, the next lower one in the add.
   assign coef_idx = (state_ff == EV_IDLE) ? deg_eff : idx_ff - COEF_IDX_W'(1);

   // Coefficient scaled into the number format.
   assign coef_acc  = {{(ACC_W-COEF_W-FRAC_BITS){coef_val[COEF_W-1]}}, coef_val,
                       {FRAC_BITS{1'b0}}};
   assign coef_wide = {coef_acc[ACC_W-1], coef_acc};

   // Shared multiplier: low half of the magnitude first, then the high half.
   assign mul_a = (state_ff == EV_MUL_LO) ? am_ff[MUL_W-1:0]
                                          : {1'b0, am_ff[ACC_W-2:MUL_W]};
   assign mul_p = mul_a * xm_ff;

   // Recombine the partial products, drop the fraction and check the range.
   assign full = {{MUL_W{1'b0}}, prod_lo_ff} + {prod_hi_ff, {MUL_W{1'b0}}};
   assign ovf  = (|full[FULL_W-1:FRAC_BITS+ACC_W-1]);

   // Signed add of the scaled coefficient; the product sign picks add or subtract.
   assign mag_wide = {2'b00, mag_ff};
   assign sum      = neg_ff ? (coef_wide - mag_wide) : (coef_wide + mag_wide);
   assign sum_max  = {2'b00, MAG_MAX};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      am_ff      <= am_in;
      xm_ff      <= xm_in;
      x_neg_ff   <= x_neg_in;
      neg_ff     <= neg_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      mag_ff     <= mag_in;
      idx_ff     <= idx_in;
   end

   // Sequencer: one Horner step is abs, two multiplies, scale and add.
   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      am_in      = am_ff;
      xm_in      = xm_ff;
      x_neg_in   = x_neg_ff;
      neg_in     = neg_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      mag_in     = mag_ff;
      idx_in     = idx_ff;
      ev_rsp.done  = 1'b0;
      ev_rsp.value = acc_ff;

      unique case (state_ff)
         EV_IDLE: begin
            if (ev_req.start) begin
               acc_in   = coef_acc;
               idx_in   = deg_eff;
               x_neg_in = ev_req.x[X_W-1];
               xm_in    = ev_req.x[X_W-1] ? MUL_W'(-ev_req.x) : MUL_W'(ev_req.x);
               state_in = (deg_eff == '0) ? EV_DONE : EV_ABS;
            end
         end
         EV_ABS: begin
            neg_in   = acc_ff[ACC_W-1] ^ x_neg_ff;
            am_in    = acc_ff[ACC_W-1] ? (ACC_W-1)'(-acc_ff) : acc_ff[ACC_W-2:0];
            state_in = EV_MUL_LO;
         end
         EV_MUL_LO: begin
            prod_lo_in = mul_p;
            state_in   = EV_MUL_HI;
         end
         EV_MUL_HI: begin
            prod_hi_in = mul_p;
            state_in   = EV_SCALE;
         end
         EV_SCALE: begin
            mag_in   = ovf ? MAG_MAX : full[FRAC_BITS+ACC_W-2:FRAC_BITS];
            state_in = EV_ADD;
         end
         EV_ADD: begin
            if (sum > sum_max) begin
               acc_in = {1'b0, MAG_MAX};
            end else if (sum < -sum_max) begin
               acc_in = ACC_W'(-sum_max);
            end else begin
               acc_in = sum[ACC_W-1:0];
            end
            idx_in   = idx_ff - COEF_IDX_W'(1);
            state_in = (idx_ff == COEF_IDX_W'(1)) ? EV_DONE : EV_ABS;
         end
         EV_DONE: begin
            ev_rsp.done = 1'b1;
            state_in    = EV_IDLE;
         end
         default: begin
            state_in = EV_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/polynomial_bisection_root.sv
// ---------------------------------------------------------------------------
// polynomial_bisection_root: bisection root finder over a Horner evaluator
// A load word leaves the block idle. A find word evaluates both ends, then up to 33
// midpoints, and holds the block until its result is taken; a no-root answer
// evaluates only the two ends. One word is in flight at a time.
// Reset clears the coefficient store at once and sets degree 0, epsilon 66.
// ---------------------------------------------------------------------------
`include "polynomial_bisection_root_defines.svh"

module polynomial_bisection_root
   import pbr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [COEF_IDX_W-1:0]        req_coef_index,
   input  logic signed [COEF_W-1:0]     req_coef_value,
   input  logic signed [X_W-1:0]        req_lower_bound,
   input  logic signed [X_W-1:0]        req_upper_bound,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [X_W-1:0]        rsp_root,
   output logic                         rsp_status,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   pbr_state_type           state_ff, state_in;
   logic signed [X_W-1:0]   lo_ff, lo_in;
   logic signed [X_W-1:0]   hi_ff, hi_in;
   logic signed [X_W-1:0]   mid_ff, mid_in;
   logic                    plo_neg_ff, plo_neg_in;
   logic                    plo_zero_ff, plo_zero_in;
   logic signed [X_W-1:0]   root_ff, root_in;
   logic                    status_ff, status_in;
   logic                    start_ff, start_in;
   logic [DEGREE_W-1:0]     degree_ff;
   logic [EPS_W-1:0]        epsilon_ff;
   logic signed [COEF_W-1:0] coef_ff [COEF_DEPTH];

   logic                    coef_we;
   logic [COEF_IDX_W-1:0]   rd_idx;
   logic [EPS_W-1:0]        eps_eff;
   logic signed [ACC_W-1:0] eps_acc;
   logic signed [X_W+1:0]   eps_span;
   logic signed [X_W+1:0]   span;
   logic signed [X_W:0]     mid_sum;
   logic signed [ACC_W-1:0] pm;
   logic                    pm_neg;
   logic                    pm_zero;
   logic                    val_big;
   logic                    span_big;
   logic                    opposite;
   pbr_eval_req_type        ev_req;
   pbr_eval_rsp_type        ev_rsp;

   // Polynomial evaluator.
   pbr_horner u_horner (
      .clock    (clock),
      .reset    (reset),
      .degree   (degree_ff),
      .ev_req   (ev_req),
      .coef_idx (rd_idx),
      .coef_val (coef_ff[rd_idx]),
      .ev_rsp   (ev_rsp)
   );

   assign ev_req.start = start_ff;
   assign ev_req.x     = (state_ff == ST_EVAL_LO) ? lo_ff :
                         (state_ff == ST_EVAL_HI) ? hi_ff : mid_ff;

   // Handshake and result ports.
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign rsp_root   = root_ff;
   assign rsp_status = status_ff;

   // A zero epsilon behaves as one so that the halving always ends.
   assign eps_eff  = (epsilon_ff == '0) ? EPS_W'(1) : epsilon_ff;
   assign eps_acc  = {{(ACC_W-EPS_W){1'b0}}, eps_eff};
   assign eps_span = {{(X_W+2-EPS_W){1'b0}}, eps_eff};

   // Stop tests on the value at the midpoint and on the interval width.
   assign pm       = ev_rsp.value;
   assign pm_neg   = pm[ACC_W-1];
   assign pm_zero  = (pm == '0);
   assign val_big  = (pm > eps_acc) || (pm < -eps_acc);
   assign span     = {{2{hi_ff[X_W-1]}}, hi_ff} - {{2{lo_ff[X_W-1]}}, lo_ff};
   assign span_big = (span > eps_span) || (span < -eps_span);
   assign opposite = !pm_zero && !plo_zero_ff && (pm_neg != plo_neg_ff);

   // Floor of the mean of the two ends.
   assign mid_sum = {lo_ff[X_W-1], lo_ff} + {hi_ff[X_W-1], hi_ff};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff  <= DEGREE_RESET;
         epsilon_ff <= EPS_RESET;
      end else if (csr_write_enable) begin
         unique case (pbr_csr_type'(csr_index))
            CSR_DEGREE:  degree_ff  <= csr_write_data[DEGREE_W-1:0];
            CSR_EPSILON: epsilon_ff <= csr_write_data[EPS_W-1:0];
            default: begin
               degree_ff <= degree_ff;
            end
         endcase
      end
   end

   // Coefficient store, cleared at reset.
   assign coef_we = req_valid && req_ready && (req_command == CMD_LOAD) &&
                    (int'(req_coef_index) <= MAX_DEGREE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_DEPTH; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (coef_we) begin
         coef_ff[COEF_IDX_W'(req_coef_index)] <= req_coef_value;
      end
   end

   // Sequencer state and evaluator start.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

   // Interval, sign and result registers.
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      plo_neg_ff  <= plo_neg_in;
      plo_zero_ff <= plo_zero_in;
      root_ff     <= root_in;
      status_ff   <= status_in;
   end

   // Bisection sequencer: evaluate both ends, answer no-root if they share a sign, else halve until a stop test holds.
   always_comb begin
      state_in    = state_ff;
      start_in    = 1'b0;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      plo_neg_in  = plo_neg_ff;
      plo_zero_in = plo_zero_ff;
      root_in     = root_ff;
      status_in   = status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_command == CMD_FIND)) begin
               lo_in    = req_lower_bound;
               hi_in    = req_upper_bound;
               start_in = 1'b1;
               state_in = ST_EVAL_LO;
            end
         end
         ST_EVAL_LO: begin
            if (ev_rsp.done) begin
               plo_neg_in  = pm_neg;
               plo_zero_in = pm_zero;
               start_in    = 1'b1;
               state_in    = ST_EVAL_HI;
            end
         end
         ST_EVAL_HI: begin
            if (ev_rsp.done) begin
               if (!plo_zero_ff && !pm_zero && (plo_neg_ff == pm_neg)) begin
                  root_in   = '0;
                  status_in = STATUS_NO_ROOT;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            mid_in   = mid_sum[X_W:1];
            start_in = 1'b1;
            state_in = ST_EVAL_MID;
         end
         ST_EVAL_MID: begin
            if (ev_rsp.done) begin
               if (val_big && span_big) begin
                  if (opposite) begin
                     hi_in = mid_ff;
                  end else begin
                     lo_in       = mid_ff;
                     plo_neg_in  = pm_neg;
                     plo_zero_in = pm_zero;
                  end
                  state_in = ST_SPLIT;
               end else begin
                  root_in   = mid_ff;
                  status_in = STATUS_FOUND;
                  state_in  = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // One word at a time: no new word while a result waits.
   `PBR_ASSERT_SAME(a_rsp_blocks_req, clock, reset, rsp_valid, !req_ready)
   // A find word makes the block busy in the next cycle.
   `PBR_ASSERT_NEXT(a_find_busy, clock, reset,
      req_valid && req_ready && (req_command == CMD_FIND), !req_ready)
   // The evaluator finishes only while the sequencer waits for it.
   `PBR_ASSERT_SAME(a_done_in_eval, clock, reset, ev_rsp.done,
      (state_ff == ST_EVAL_LO) || (state_ff == ST_EVAL_HI) || (state_ff == ST_EVAL_MID))
   // A no-root result carries a zero root.
   `PBR_ASSERT_SAME(a_no_root_zero, clock, reset,
      rsp_valid && (rsp_status == STATUS_NO_ROOT), rsp_root == '0)

endmodule

>>> test/pbr_root_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Root finder scoreboard
// Keeps a shadow copy of the coefficient store and the degree and tolerance
// registers. It works out the answer of every accepted search word and
// compares each returned word with the oldest answer still waiting.
// ----------------------------------------------------------------------------
package pbr_root_scoreboard_pkg;
   import pbr_pkg::*;

   // Largest magnitude the accumulator can hold; it saturates symmetrically.
   localparam longint ACC_LIMIT = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint FX_ONE    = 64'sd1 <<< FRAC_BITS;

   typedef struct packed {
      logic signed [X_W-1:0] root;
      pbr_status_type        status;
   } root_answer_type;

   class root_scoreboard;
      shortint          coef_shadow[COEF_DEPTH];
      logic [DEGREE_W-1:0] degree_shadow;
      logic [EPS_W-1:0]    tolerance_shadow;
      root_answer_type  answers_q[$];
      int               failures;
      int               checked;
      int               roots_found;
      int               no_root_count;

      function new();
         foreach (coef_shadow[i]) coef_shadow[i] = 0;
         degree_shadow    = DEGREE_RESET;
         tolerance_shadow = EPS_RESET;
         failures         = 0;
         checked          = 0;
         roots_found      = 0;
         no_root_count    = 0;
      endfunction

      function void write_register(pbr_csr_type index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_DEGREE) degree_shadow = data[DEGREE_W-1:0];
         else tolerance_shadow = data[EPS_W-1:0];
      endfunction

      function int pending();
         return answers_q.size();
      endfunction

      // Multiply by x and drop the fraction bits, truncating toward zero.
      function longint scale_by_x(longint acc, longint x);
         logic [127:0] mag;
         logic [63:0]  acc_mag;
         logic [63:0]  x_mag;
         logic         negative;
         negative = (acc < 0) != (x < 0);
         acc_mag  = (acc < 0) ? -acc : acc;
         x_mag    = (x < 0) ? -x : x;
         mag      = {64'd0, acc_mag} * {64'd0, x_mag};
         mag      = mag >> FRAC_BITS;
         if (mag > {64'd0, ACC_LIMIT}) return negative ? -ACC_LIMIT : ACC_LIMIT;
         return negative ? -longint'(mag[63:0]) : longint'(mag[63:0]);
      endfunction

      function longint add_clamped(longint a, longint b);
         logic signed [65:0] sum;
         sum = a;
         sum = sum + b;
         if (sum > ACC_LIMIT) return ACC_LIMIT;
         if (sum < -ACC_LIMIT) return -ACC_LIMIT;
         return longint'(sum);
      endfunction

      // Horner's rule over coefficients 0..degree.
      function longint poly_value(longint x);
         longint acc;
         int     top;
         top = int'(degree_shadow);
         acc = longint'(coef_shadow[top]) * FX_ONE;
         for (int i = top; i > 0; i--) begin
            acc = scale_by_x(acc, x);
            acc = add_clamped(acc, longint'(coef_shadow[i-1]) * FX_ONE);
         end
         return acc;
      endfunction

      function int sign_of(longint v);
         return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
      endfunction

      function longint magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // Bisect until the value or the width is within the tolerance.
      function root_answer_type bisect(logic signed [X_W-1:0] lower,
                                       logic signed [X_W-1:0] upper);
         root_answer_type answer;
         longint lo, hi, mid, p_lo, p_mid, tol;
         lo   = longint'(lower);
         hi   = longint'(upper);
         tol  = (tolerance_shadow == 0) ? 64'sd1 : longint'(tolerance_shadow);
         p_lo = poly_value(lo);
         if (sign_of(p_lo) * sign_of(poly_value(hi)) > 0) begin
            answer.root   = '0;
            answer.status = STATUS_NO_ROOT;
            return answer;
         end
         mid   = (lo + hi) >>> 1;
         p_mid = poly_value(mid);
         while (magnitude(p_mid) > tol && magnitude(hi - lo) > tol) begin
            if (sign_of(p_mid) * sign_of(p_lo) < 0) begin
               hi = mid;
            end else begin
               lo   = mid;
               p_lo = p_mid;
            end
            mid   = (lo + hi) >>> 1;
            p_mid = poly_value(mid);
         end
         answer.root   = mid[X_W-1:0];
         answer.status = STATUS_FOUND;
         return answer;
      endfunction

      // Called for every word the block accepts.
      function void note_word(pbr_cmd_type command, logic [COEF_IDX_W-1:0] index,
                              logic signed [COEF_W-1:0] value,
                              logic signed [X_W-1:0] lower,
                              logic signed [X_W-1:0] upper);
         root_answer_type answer;
         if (command == CMD_LOAD) begin
            coef_shadow[index] = value;
         end else begin
            answer = bisect(lower, upper);
            if (answer.status == STATUS_FOUND) roots_found++;
            else no_root_count++;
            answers_q.push_back(answer);
         end
      endfunction

      task report(string msg);
         failures++;
         $display("tb_top: mismatch at result %0d: %s", checked, msg);
      endtask

      task check_result(logic signed [X_W-1:0] root, logic status);
         root_answer_type want;
         checked++;
         if (answers_q.size() == 0) begin
            report($sformatf("root %0d status %0b arrived with no search waiting",
                             root, status));
            return;
         end
         want = answers_q.pop_front();
         if (root !== want.root)
            report($sformatf("root %0d, expected %0d", root, want.root));
         if (status !== want.status)
            report($sformatf("status %0b, expected %0b", status, want.status));
      endtask

      task report_leftovers();
         while (answers_q.size() > 0) begin
            report($sformatf("expected root %0d never returned", answers_q[0].root));
            void'(answers_q.pop_front());
         end
      endtask
   endclass

endpackage

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for polynomial_bisection_root
// Loads coefficients, sets degree and tolerance, and sends root searches
// over directed and random intervals with random idling on both channels.
// Every returned word is checked against a scoreboard that bisects itself.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pbr_pkg::*;
   import pbr_root_scoreboard_pkg::*;

   localparam int IDLE_PCT       = 29;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WORDS_PER_SET  = 64;
   localparam logic signed [X_W-1:0] ONE = 32'sd65536;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid       = 1'b0;
   logic                     req_ready;
   logic                     req_command     = 1'b0;
   logic [COEF_IDX_W-1:0]    req_coef_index  = '0;
   logic signed [COEF_W-1:0] req_coef_value  = '0;
   logic signed [X_W-1:0]    req_lower_bound = '0;
   logic signed [X_W-1:0]    req_upper_bound = '0;
   logic                     rsp_valid;
   logic                     rsp_ready       = 1'b0;
   logic signed [X_W-1:0]    rsp_root;
   logic                     rsp_status;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index        = '0;
   logic [CSR_DATA_W-1:0]    csr_write_data   = '0;

   root_scoreboard sb = new();
   bit quiet_mode = 1'b0;
   int words_sent = 0;
   int loads_sent = 0;
   int searches_sent = 0;

   polynomial_bisection_root dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_root         (rsp_root),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one word, idling first at random, and hold it until accepted.
   task automatic send_word(pbr_cmd_type command, logic [COEF_IDX_W-1:0] index,
                            logic signed [COEF_W-1:0] value,
                            logic signed [X_W-1:0] lower,
                            logic signed [X_W-1:0] upper);
      while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= command;
      req_coef_index  <= index;
      req_coef_value  <= value;
      req_lower_bound <= lower;
      req_upper_bound <= upper;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(command, index, value, lower, upper);
      words_sent++;
      if (command == CMD_LOAD) loads_sent++;
      else searches_sent++;
   endtask

   // The fields a word does not use carry random bits.
   task automatic load_coefficient(int index, int value);
      send_word(CMD_LOAD, COEF_IDX_W'(index), COEF_W'(value), $urandom, $urandom);
   endtask

   task automatic search_root(logic signed [X_W-1:0] lower, logic signed [X_W-1:0] upper);
      send_word(CMD_FIND, COEF_IDX_W'($urandom), COEF_W'($urandom), lower, upper);
   endtask

   // Wait until every answer is back and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers while the block is idle.
   task automatic program_registers(logic [CSR_DATA_W-1:0] degree_data,
                                    logic [CSR_DATA_W-1:0] epsilon_data);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEGREE;
      csr_write_data   <= degree_data;
      @(posedge clock);
      csr_index        <= CSR_EPSILON;
      csr_write_data   <= epsilon_data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_register(CSR_DEGREE, degree_data);
      sb.write_register(CSR_EPSILON, epsilon_data);
   endtask

   // Mostly small coefficients, so that sign changes are common.
   function automatic int random_coef();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return int'($urandom_range(16)) - 8;
      if (pick < 85) return int'($urandom_range(2000)) - 1000;
      return int'($signed(16'($urandom)));
   endfunction

   function automatic logic signed [X_W-1:0] random_bound();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return X_W'(int'($urandom_range(1 << 20)) - (1 << 19));
      if (pick < 65) return X_W'(int'($urandom_range(1 << 27)) - (1 << 26));
      if (pick < 85) return X_W'($urandom);
      case ($urandom_range(4))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3: return ONE;
         default: return -ONE;
      endcase
   endfunction

   // Returned words are checked here; the ready line idles in the same place.
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_root, rsp_status);
            if (sb.checked == 30 || sb.checked == 120) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Ends the run if no word moves on either channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: no word moved for %0d cycles", quiet_cycles);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int degree_pick;
      int epsilon_pick;
      int count;
      int roll;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: all-zero polynomial, then a nonzero constant.
      search_root(-ONE, ONE);
      load_coefficient(0, 5);
      search_root(-ONE, ONE);

      // p(x) = x - 3: normal, reversed, no sign change, root at the lower end.
      program_registers(17'd1, 17'd66);
      load_coefficient(0, -3);
      load_coefficient(1, 1);
      search_root(0, 10 * ONE);
      search_root(10 * ONE, 0);
      search_root(4 * ONE, 10 * ONE);
      search_root(3 * ONE, 5 * ONE);

      // Zero tolerance, full degree, extreme coefficients and bounds.
      program_registers(17'd7, 17'd0);
      load_coefficient(7, 32767);
      load_coefficient(0, -32768);
      search_root(32'sh8000_0000, 32'sh7FFF_FFFF);
      search_root(0, ONE);
      search_root(-ONE, 2 * ONE);

      // p(x) = x^2 - 2 with a tolerance of 65536; high data bits ignored.
      program_registers(17'h1FFFA, 17'd65536);
      load_coefficient(2, 1);
      load_coefficient(1, 0);
      load_coefficient(0, -2);
      search_root(0, 2 * ONE);
      search_root(32'sh7FFF_FFFF, 32'sh8000_0000);

      // Random sets: each set picks a degree and a tolerance.
      for (int set_no = 0; set_no < 7; set_no++) begin
         case (set_no)
            0: begin degree_pick = 0; epsilon_pick = $urandom_range(1, 65536); end
            1: begin degree_pick = 7; epsilon_pick = 1; end
            2: begin degree_pick = 3; epsilon_pick = 65536; end
            3: begin degree_pick = 5; epsilon_pick = 0; end
            4: begin degree_pick = 1; epsilon_pick = 131071; end
            default: begin
               degree_pick  = $urandom_range(7);
               epsilon_pick = $urandom_range(131071);
            end
         endcase
         program_registers((CSR_DATA_W'($urandom) & ~CSR_DATA_W'(7)) | CSR_DATA_W'(degree_pick),
                           CSR_DATA_W'(epsilon_pick));
         quiet_mode = (set_no == 2);
         count = 0;
         while (count < WORDS_PER_SET) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
               // A fresh polynomial followed by a few searches over it.
               for (int i = 0; i <= degree_pick; i++) begin
                  load_coefficient(($urandom_range(1) == 1) ? i : degree_pick - i,
                                   random_coef());
                  count++;
               end
               repeat ($urandom_range(1, 3)) begin
                  search_root(random_bound(), random_bound());
                  count++;
               end
            end else if (roll < 85) begin
               search_root(random_bound(), random_bound());
               count++;
            end else begin
               load_coefficient($urandom_range(7), random_coef());
               count++;
            end
         end
      end
      quiet_mode = 1'b0;

      drain();
      sb.report_leftovers();
      $display("tb_top: %0d words sent, %0d coefficient loads and %0d searches",
               words_sent, loads_sent, searches_sent);
      $display("tb_top: %0d results checked, %0d roots found, %0d without sign change",
               sb.checked, sb.roots_found, sb.no_root_count);
      if (sb.failures == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
